// ===== hdl/selms_pkg.sv =====
// ----------------------------------------------------------------------------
// selms_pkg
// Shared constants, types and command bundle for the sign-error LMS FIR.
// ----------------------------------------------------------------------------
`default_nettype none

package selms_pkg;

    // Filter geometry
    localparam int TAPS    = 15;
    localparam int IDX_W   = $clog2(TAPS);
    localparam int CENTRE  = TAPS / 2;

    // Field and datapath widths
    localparam int SMP_W   = 16;                 // Q1.15 samples
    localparam int TAP_W   = 24;                 // Q3.21 taps
    localparam int STEP_W  = 16;                 // step in units of 2^-16
    localparam int OPB_W   = 17;                 // second multiplier operand
    localparam int PROD_W  = TAP_W + OPB_W;      // 41
    localparam int ACC_W   = 43;                 // holds TAPS products of 2^38
    localparam int UPD_W   = 33;                 // sample times step
    localparam int DELTA_W = UPD_W - 10;         // rounded update, Q.21
    localparam int TSUM_W  = TAP_W + 2;

    // Reset values
    localparam logic signed [TAP_W-1:0] TAP_ONE    = TAP_W'(2097152);
    localparam logic [STEP_W-1:0]       STEP_RESET = STEP_W'(655);

    // Item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_ADAPT  = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_LAST,
        ST_FINISH
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic             capture;   // take the request's fields
        logic             kind;      // kind of the request in hand
        logic             mul_en;    // multiply stage for tap idx
        logic             acc_en;    // accumulate or tap write stage
        logic             finish;    // close the request, load result
        logic [IDX_W-1:0] idx;       // tap being multiplied
    } cmd_t;

endpackage

`default_nettype wire

// ===== hdl/selms_ctrl.sv =====
// ----------------------------------------------------------------------------
// selms_ctrl
// Sequencer: walks the taps through the shared multiplier for each request
// and manages both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module selms_ctrl
    import selms_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    input  wire logic kind,
    output logic      out_valid,
    input  wire logic out_stall,
    output cmd_t      cmd
);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             kind_reg, kind_next;
    logic             out_valid_reg, out_valid_next;

    // State and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            kind_reg      <= KIND_SAMPLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        kind_next   = kind_reg;
        in_stall    = 1'b1;
        cmd         = '0;
        cmd.kind    = kind_reg;
        cmd.idx     = cnt_reg;

        // result taken downstream
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    cmd.kind    = kind;
                    kind_next   = kind;
                    cnt_next    = '0;
                    state_next  = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.mul_en = 1'b1;
                cmd.acc_en = (cnt_reg != '0);
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == IDX_W'(TAPS - 1))
                    state_next = ST_LAST;
            end
            ST_LAST:
            begin
                // drain the final product
                cmd.acc_en = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // wait for the output register to be free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

`ifndef NO_ASSERTIONS
    // a request that is accepted blocks the next one in the following cycle
    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request accepted while a request was in hand");

    // finishing never overwrites a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || !out_stall))
        else $error("result overwritten before it was taken");

    // every finish presents a result in the next cycle
    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid)
        else $error("finished request produced no result");

    // capture never overlaps with multiply, accumulate or finish
    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> (!cmd.mul_en && !cmd.acc_en && !cmd.finish))
        else $error("capture overlaps with datapath work");
`endif

endmodule

`default_nettype wire

// ===== hdl/selms_dp.sv =====
// ----------------------------------------------------------------------------
// selms_dp
// Datapath: delay line, tap weights, shared multiplier, accumulator,
// output history and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module selms_dp
    import selms_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire cmd_t                     cmd,
    input  wire logic                     cfg_wr_en,
    input  wire logic [STEP_W-1:0]        cfg_wr_data,
    input  wire logic signed [SMP_W-1:0]  sample,
    input  wire logic signed [SMP_W-1:0]  desired,
    input  wire logic signed [SMP_W-1:0]  actual,
    output logic signed [SMP_W-1:0]       filt_oldest,
    output logic signed [SMP_W-1:0]       filt_middle,
    output logic signed [SMP_W-1:0]       filt_newest
);

    logic signed [SMP_W-1:0]  dl_reg   [TAPS];
    logic signed [TAP_W-1:0]  tap_reg  [TAPS];
    logic signed [SMP_W-1:0]  hist_reg [3];
    logic signed [SMP_W-1:0]  out_reg  [3];
    logic [STEP_W-1:0]        step_reg;
    logic                     up_reg, dn_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [IDX_W-1:0]         idx_d_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic signed [TAP_W-1:0]   op_a;
    logic signed [OPB_W-1:0]   op_b;
    logic signed [UPD_W-1:0]   upd_rnd;
    logic signed [DELTA_W-1:0] delta;
    logic signed [TSUM_W-1:0]  tap_sum;
    logic signed [TAP_W-1:0]   tap_next;
    logic signed [ACC_W:0]     acc_rnd;
    logic signed [ACC_W-21:0]  filt_full;
    logic signed [SMP_W-1:0]   filt_next;

    // Operand select: tap by sample for filtering, sample by step for adapting
    always_comb
    begin
        if (cmd.kind == KIND_SAMPLE)
        begin
            op_a = tap_reg[cmd.idx];
            op_b = OPB_W'(dl_reg[cmd.idx]);
        end
        else
        begin
            op_a = TAP_W'(dl_reg[cmd.idx]);
            op_b = $signed({1'b0, step_reg});
        end
    end

    // Tap update: round to Q3.21, add or subtract, saturate
    always_comb
    begin
        upd_rnd = prod_reg[UPD_W-1:0] + UPD_W'(512);
        delta   = upd_rnd[UPD_W-1:10];
        if (up_reg)
            tap_sum = TSUM_W'(tap_reg[idx_d_reg]) + TSUM_W'(delta);
        else
            tap_sum = TSUM_W'(tap_reg[idx_d_reg]) - TSUM_W'(delta);
        if (tap_sum > $signed(TSUM_W'({1'b0, {(TAP_W-1){1'b1}}})))
            tap_next = {1'b0, {(TAP_W-1){1'b1}}};
        else if (tap_sum < -$signed(TSUM_W'({1'b1, {(TAP_W-1){1'b0}}})))
            tap_next = {1'b1, {(TAP_W-1){1'b0}}};
        else
            tap_next = tap_sum[TAP_W-1:0];
    end

    // Filter output: round to Q1.15 and saturate
    always_comb
    begin
        acc_rnd   = (ACC_W+1)'(acc_reg) + (ACC_W+1)'(1 << 20);
        filt_full = acc_rnd[ACC_W:21];
        if (filt_full > (ACC_W-20)'(32767))
            filt_next = 16'sh7FFF;
        else if (filt_full < -(ACC_W-20)'(32768))
            filt_next = 16'sh8000;
        else
            filt_next = filt_full[SMP_W-1:0];
    end

    // Step size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= STEP_RESET;
        else if (cfg_wr_en)
            step_reg <= cfg_wr_data;
    end

    // Delay line and error direction capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAPS; i++)
                dl_reg[i] <= '0;
            up_reg <= 1'b0;
            dn_reg <= 1'b0;
        end
        else if (cmd.capture)
        begin
            if (cmd.kind == KIND_SAMPLE)
            begin
                for (int i = 0; i < TAPS - 1; i++)
                    dl_reg[i] <= dl_reg[i+1];
                dl_reg[TAPS-1] <= sample;
            end
            else
            begin
                up_reg <= (desired > actual);
                dn_reg <= (desired < actual);
            end
        end
    end

    // Multiply stage
    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg  <= PROD_W'(op_a) * PROD_W'(op_b);
            idx_d_reg <= cmd.idx;
        end
    end

    // Accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else if (cmd.capture)
            acc_reg <= '0;
        else if (cmd.acc_en && cmd.kind == KIND_SAMPLE)
            acc_reg <= acc_reg + ACC_W'(prod_reg);
    end

    // Tap weights, centre spike after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAPS; i++)
                tap_reg[i] <= (i == CENTRE) ? TAP_ONE : '0;
        end
        else if (cmd.acc_en && cmd.kind == KIND_ADAPT && (up_reg || dn_reg))
        begin
            tap_reg[idx_d_reg] <= tap_next;
        end
    end

    // Output history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
                hist_reg[i] <= '0;
        end
        else if (cmd.finish && cmd.kind == KIND_SAMPLE)
        begin
            hist_reg[0] <= hist_reg[1];
            hist_reg[1] <= hist_reg[2];
            hist_reg[2] <= filt_next;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            if (cmd.kind == KIND_SAMPLE)
            begin
                out_reg[0] <= hist_reg[1];
                out_reg[1] <= hist_reg[2];
                out_reg[2] <= filt_next;
            end
            else
            begin
                out_reg[0] <= hist_reg[0];
                out_reg[1] <= hist_reg[1];
                out_reg[2] <= hist_reg[2];
            end
        end
    end

    assign filt_oldest = out_reg[0];
    assign filt_middle = out_reg[1];
    assign filt_newest = out_reg[2];

`ifndef NO_ASSERTIONS
    // taps are only written while adapting
    a_tap_write_adapt: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.acc_en && cmd.kind == KIND_SAMPLE)
            |=> (tap_reg[$past(idx_d_reg)] == $past(tap_reg[idx_d_reg])))
        else $error("tap written during a filter request");

    // error direction is never both up and down
    a_dir_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(up_reg && dn_reg))
        else $error("error direction both up and down");

    // adapt requests leave the delay line alone
    a_dl_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.capture && cmd.kind == KIND_ADAPT) |=> $stable(dl_reg[TAPS-1]))
        else $error("delay line moved on an adapt request");
`endif

endmodule

`default_nettype wire

// ===== hdl/sign_error_lms_fir.sv =====
// ----------------------------------------------------------------------------
// sign_error_lms_fir
// Adaptive FIR equaliser with a sign-error LMS tap update.
// ----------------------------------------------------------------------------
//
//  channel   | handshake           | payload
//  ----------+---------------------+-------------------------------------------
//  input     | in_valid, in_stall  | kind, sample, desired, actual
//  output    | out_valid, out_stall| filt_oldest, filt_middle, filt_newest
//  config    | cfg_wr_en           | cfg_wr_data (step_size)
//
//  A request is captured, walked through the single shared multiplier one
//  tap per cycle, drained and then closed; in_stall holds off the next
//  request until the request in hand is closed.
//  The result register lets a new request be taken while the last result
//  still waits; closing the next request waits while out_stall holds it.
//  rst_n is asynchronous and loads the centre spike taps and zero history.
//
`default_nettype none

module sign_error_lms_fir
    import selms_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_wr_en,
    input  wire logic [STEP_W-1:0]        cfg_wr_data,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic                     kind,
    input  wire logic signed [SMP_W-1:0]  sample,
    input  wire logic signed [SMP_W-1:0]  desired,
    input  wire logic signed [SMP_W-1:0]  actual,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic signed [SMP_W-1:0]       filt_oldest,
    output logic signed [SMP_W-1:0]       filt_middle,
    output logic signed [SMP_W-1:0]       filt_newest
);

    cmd_t cmd;

    // Sequencer
    selms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // Datapath
    selms_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .sample      (sample),
        .desired     (desired),
        .actual      (actual),
        .filt_oldest (filt_oldest),
        .filt_middle (filt_middle),
        .filt_newest (filt_newest)
    );

endmodule

`default_nettype wire
